// ===== src/stn_pkg.sv =====
// ----------------------------------------------------------------------------
// stn_pkg: shared types and constants for the stepper turn sequencer
// Opcodes, move flag positions, widths, the half-step coil table and the
// command struct that the move controller sends to each channel.
// ----------------------------------------------------------------------------
package stn_pkg;

  typedef enum logic [1:0] {
    OP_START   = 2'd0,
    OP_RELEASE = 2'd1,
    OP_TICK    = 2'd2,
    OP_NONE    = 2'd3
  } stn_op_t;

  // Configuration register indexes.
  localparam logic [1:0] CFG_QUARTER   = 2'd0;
  localparam logic [1:0] CFG_OVERSHOOT = 2'd1;
  localparam logic [1:0] CFG_TICKS     = 2'd2;

  localparam int QUARTER_W   = 12;
  localparam int OVERSHOOT_W = 8;
  localparam int TICKS_W     = 16;
  localparam int STEPS_W     = 14;
  localparam int PHASE_W     = 3;
  localparam int COIL_W      = 4;
  localparam int CFG_DATA_W  = 16;

  localparam logic [QUARTER_W-1:0]   QUARTER_RESET   = 12'd1024;
  localparam logic [OVERSHOOT_W-1:0] OVERSHOOT_RESET = 8'd16;
  localparam logic [TICKS_W-1:0]     TICKS_RESET     = 16'd1;

  // Bit positions inside the latched move flags.
  localparam int FLAG_OVS   = 0;
  localparam int FLAG_USE_A = 1;
  localparam int FLAG_USE_B = 2;
  localparam int FLAG_REV_A = 3;
  localparam int FLAG_REV_B = 4;
  localparam int FLAGS_W    = 5;

  // Per-channel command for one accepted item.
  typedef struct packed {
    logic release_coils;
    logic step;
    logic down;
  } stn_chan_cmd_t;

  // Eight-phase half-step pattern, bit0 is coil 1.
  function automatic logic [COIL_W-1:0] coil_pattern(input logic [PHASE_W-1:0] phase);
    logic [COIL_W-1:0] pat;
    begin
      case (phase)
        3'd0:    pat = 4'h8;
        3'd1:    pat = 4'hC;
        3'd2:    pat = 4'h4;
        3'd3:    pat = 4'h6;
        3'd4:    pat = 4'h2;
        3'd5:    pat = 4'h3;
        3'd6:    pat = 4'h1;
        3'd7:    pat = 4'h9;
        default: pat = 4'h0;
      endcase
      return pat;
    end
  endfunction

endpackage

// ===== src/stepper_turn_sequencer.sv =====
// ----------------------------------------------------------------------------
// stepper_turn_sequencer: two-channel half-step stepper turn sequencer
// Runs quarter or half turns with optional overshoot and back-off on two
// four-coil channels, one half-step every ticks_per_step tick items.
// ----------------------------------------------------------------------------
// Latency: the result of an item is on the output in the cycle after it is accepted.
// Throughput: one item per cycle while out_ready is high; the single output register is refilled in
// the same cycle that its item is taken.
// Reset (synchronous, active high) clears the move, phases and energized flags,
// empties the output register and loads the register defaults 1024, 16 and 1.
// Configuration writes are always taken, in the cycle they are offered.
module stepper_turn_sequencer (
  input  logic                              clk,
  input  logic                              rst,
  // Command items.
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [1:0]                        opcode,
  input  logic                              use_a,
  input  logic                              use_b,
  input  logic                              reverse_a,
  input  logic                              reverse_b,
  input  logic                              half_turn,
  input  logic                              with_overshoot,
  // Result items.
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [stn_pkg::COIL_W-1:0]        coils_a,
  output logic [stn_pkg::COIL_W-1:0]        coils_b,
  output logic                              busy_res,
  output logic                              move_done,
  // Configuration writes.
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [1:0]                        cfg_index,
  input  logic [stn_pkg::CFG_DATA_W-1:0]    cfg_data
);

  logic [stn_pkg::QUARTER_W-1:0]   quarter_turn_steps;
  logic [stn_pkg::OVERSHOOT_W-1:0] overshoot_steps;
  logic [stn_pkg::TICKS_W-1:0]     ticks_per_step;

  logic                            accept;
  stn_pkg::stn_chan_cmd_t          cmd_a;
  stn_pkg::stn_chan_cmd_t          cmd_b;
  logic [stn_pkg::COIL_W-1:0]      coils_a_next;
  logic [stn_pkg::COIL_W-1:0]      coils_b_next;
  logic                            busy_next;
  logic                            done_next;

  // The output register frees up in the same cycle its item is taken, so a
  // new item is accepted whenever the register is empty or being drained.
  assign in_ready  = !out_valid || out_ready;
  assign accept    = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  // Configuration registers. An index with no register is ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      quarter_turn_steps <= stn_pkg::QUARTER_RESET;
      overshoot_steps    <= stn_pkg::OVERSHOOT_RESET;
      ticks_per_step     <= stn_pkg::TICKS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        stn_pkg::CFG_QUARTER:   quarter_turn_steps <= cfg_data[stn_pkg::QUARTER_W-1:0];
        stn_pkg::CFG_OVERSHOOT: overshoot_steps    <= cfg_data[stn_pkg::OVERSHOOT_W-1:0];
        stn_pkg::CFG_TICKS:     ticks_per_step     <= cfg_data[stn_pkg::TICKS_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // The controller decides, per accepted item, whether the channels step or
  // release; each channel then updates its own phase and energized flag.
  stn_ctrl u_ctrl (
    .clk                (clk),
    .rst                (rst),
    .accept             (accept),
    .opcode             (opcode),
    .use_a              (use_a),
    .use_b              (use_b),
    .reverse_a          (reverse_a),
    .reverse_b          (reverse_b),
    .half_turn          (half_turn),
    .with_overshoot     (with_overshoot),
    .quarter_turn_steps (quarter_turn_steps),
    .overshoot_steps    (overshoot_steps),
    .ticks_per_step     (ticks_per_step),
    .cmd_a              (cmd_a),
    .cmd_b              (cmd_b),
    .busy_next          (busy_next),
    .done_next          (done_next)
  );

  stn_chan u_chan_a (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd_a),
    .coils_next (coils_a_next)
  );

  stn_chan u_chan_b (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd_b),
    .coils_next (coils_b_next)
  );

  // Output register: valid is control state, the payload loads on accept.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      coils_a   <= coils_a_next;
      coils_b   <= coils_b_next;
      busy_res  <= busy_next;
      move_done <= done_next;
    end
  end

`ifndef SYNTH
  // The item that finishes a move never reports the move as still running.
  a_done_not_busy: assert property (@(posedge clk) disable iff (rst)
    (out_valid && move_done) |-> !busy_res)
    else $error("move_done reported together with busy");

  // A waiting result blocks new items until it is taken.
  a_hold_blocks: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |-> !in_ready)
    else $error("item accepted while the result register is full");

  // A release item leaves both channels de-energized.
  a_release_coils: assert property (@(posedge clk) disable iff (rst)
    (accept && (opcode == stn_pkg::OP_RELEASE)) |=>
      ((coils_a == '0) && (coils_b == '0) && !busy_res))
    else $error("coils still driven after release");
`endif

endmodule

// ===== src/stn_chan.sv =====
// ----------------------------------------------------------------------------
// stn_chan: one stepper channel
// Holds the running phase and the energized flag, and gives the coil
// pattern that follows the current command.
// ----------------------------------------------------------------------------
module stn_chan (
  input  logic                         clk,
  input  logic                         rst,
  input  stn_pkg::stn_chan_cmd_t       cmd,
  output logic [stn_pkg::COIL_W-1:0]   coils_next
);

  logic [stn_pkg::PHASE_W-1:0] phase;
  logic [stn_pkg::PHASE_W-1:0] phase_next;
  logic                        energized;
  logic                        energized_next;

  always_comb begin
    phase_next     = phase;
    energized_next = energized;
    if (cmd.release_coils) begin
      energized_next = 1'b0;
    end else if (cmd.step) begin
      // Counting down by one is adding seven modulo eight.
      phase_next     = cmd.down ? phase + 3'd7 : phase + 3'd1;
      energized_next = 1'b1;
    end
  end

  assign coils_next = energized_next ? stn_pkg::coil_pattern(phase_next)
                                     : {stn_pkg::COIL_W{1'b0}};

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= '0;
      energized <= 1'b0;
    end else begin
      phase     <= phase_next;
      energized <= energized_next;
    end
  end

endmodule

// ===== src/stn_ctrl.sv =====
// ----------------------------------------------------------------------------
// stn_ctrl: move controller
// Decodes each accepted item, keeps the step count, tick counter, leg and
// latched move flags, and issues step and release commands to the channels.
// ----------------------------------------------------------------------------
module stn_ctrl (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              accept,
  input  logic [1:0]                        opcode,
  input  logic                              use_a,
  input  logic                              use_b,
  input  logic                              reverse_a,
  input  logic                              reverse_b,
  input  logic                              half_turn,
  input  logic                              with_overshoot,
  input  logic [stn_pkg::QUARTER_W-1:0]     quarter_turn_steps,
  input  logic [stn_pkg::OVERSHOOT_W-1:0]   overshoot_steps,
  input  logic [stn_pkg::TICKS_W-1:0]       ticks_per_step,
  output stn_pkg::stn_chan_cmd_t            cmd_a,
  output stn_pkg::stn_chan_cmd_t            cmd_b,
  output logic                              busy_next,
  output logic                              done_next
);

  logic [stn_pkg::STEPS_W-1:0] steps_left;
  logic [stn_pkg::STEPS_W-1:0] steps_left_next;
  logic                        in_backoff;
  logic                        in_backoff_next;
  logic [stn_pkg::TICKS_W-1:0] tick_count;
  logic [stn_pkg::TICKS_W-1:0] tick_count_next;
  logic [stn_pkg::FLAGS_W-1:0] move_flags;
  logic [stn_pkg::FLAGS_W-1:0] move_flags_next;

  logic [stn_pkg::TICKS_W-1:0] period;
  logic [stn_pkg::TICKS_W:0]   tick_inc;
  logic [stn_pkg::STEPS_W-1:0] turn_steps;
  logic [stn_pkg::STEPS_W-1:0] fwd_steps;
  logic [stn_pkg::STEPS_W-1:0] steps_dec;
  logic                        busy;
  logic                        do_start;
  logic                        do_release;
  logic                        do_tick;
  logic                        fire;
  logic                        to_backoff;

  assign busy       = (steps_left != '0);
  assign do_start   = accept && (opcode == stn_pkg::OP_START) && !busy;
  assign do_release = accept && (opcode == stn_pkg::OP_RELEASE);
  assign do_tick    = accept && (opcode == stn_pkg::OP_TICK) && busy;

  assign period   = (ticks_per_step == '0) ? {{(stn_pkg::TICKS_W-1){1'b0}}, 1'b1}
                                           : ticks_per_step;
  assign tick_inc = {1'b0, tick_count} + {{stn_pkg::TICKS_W{1'b0}}, 1'b1};
  assign fire     = do_tick && (tick_inc >= {1'b0, period});

  assign turn_steps = half_turn ? {1'b0, quarter_turn_steps, 1'b0}
                                : {2'b00, quarter_turn_steps};
  assign fwd_steps  = turn_steps + (with_overshoot ? {6'd0, overshoot_steps}
                                                   : {stn_pkg::STEPS_W{1'b0}});
  assign steps_dec  = steps_left - {{(stn_pkg::STEPS_W-1){1'b0}}, 1'b1};

  // The forward leg hands over to the back-off leg when overshoot was asked for and overshoot_steps is not zero.
  assign to_backoff = !in_backoff && move_flags[stn_pkg::FLAG_OVS]
                      && (overshoot_steps != '0);

  always_comb begin
    steps_left_next = steps_left;
    in_backoff_next = in_backoff;
    tick_count_next = tick_count;
    move_flags_next = move_flags;
    done_next       = 1'b0;
    if (do_release) begin
      steps_left_next = '0;
      in_backoff_next = 1'b0;
      tick_count_next = '0;
      move_flags_next = '0;
    end else if (do_start && (fwd_steps != '0)) begin
      steps_left_next = fwd_steps;
      in_backoff_next = 1'b0;
      tick_count_next = '0;
      move_flags_next = {reverse_b, reverse_a, use_b, use_a, with_overshoot};
    end else if (fire) begin
      tick_count_next = '0;
      if (steps_dec != '0) begin
        steps_left_next = steps_dec;
      end else if (to_backoff) begin
        in_backoff_next = 1'b1;
        steps_left_next = {6'd0, overshoot_steps};
      end else begin
        done_next       = 1'b1;
        steps_left_next = '0;
        in_backoff_next = 1'b0;
        move_flags_next = '0;
      end
    end else if (do_tick) begin
      tick_count_next = tick_inc[stn_pkg::TICKS_W-1:0];
    end
  end

  assign busy_next = (steps_left_next != '0);

  always_comb begin
    cmd_a.release_coils = do_release;
    cmd_a.step          = fire && move_flags[stn_pkg::FLAG_USE_A];
    cmd_a.down          = move_flags[stn_pkg::FLAG_REV_A] ^ in_backoff;
    cmd_b.release_coils = do_release;
    cmd_b.step          = fire && move_flags[stn_pkg::FLAG_USE_B];
    cmd_b.down          = move_flags[stn_pkg::FLAG_REV_B] ^ in_backoff;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      steps_left <= '0;
      in_backoff <= 1'b0;
      tick_count <= '0;
      move_flags <= '0;
    end else begin
      steps_left <= steps_left_next;
      in_backoff <= in_backoff_next;
      tick_count <= tick_count_next;
      move_flags <= move_flags_next;
    end
  end

`ifndef SYNTH
  // An idle controller carries no leftover timing, leg or flags.
  a_idle_clean: assert property (@(posedge clk) disable iff (rst)
    (steps_left == '0) |-> ((tick_count == '0) && !in_backoff && (move_flags == '0)))
    else $error("idle controller holds stale move state");

  // The back-off leg only exists for a move that asked for overshoot.
  a_backoff_ovs: assert property (@(posedge clk) disable iff (rst)
    in_backoff |-> move_flags[stn_pkg::FLAG_OVS])
    else $error("back-off leg without overshoot flag");

  // While a move runs, the tick counter stays below the step period.
  a_tick_bound: assert property (@(posedge clk) disable iff (rst)
    busy |-> (tick_inc <= {1'b0, period}))
    else $error("tick counter ran past the step period");
`endif

endmodule
